@@ design/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and codes of the bitmap frame allocator: request kinds,
// response payload and the result of the map word unit.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int MAP_WORD_BITS = 32;
  localparam int PAGE_SHIFT    = 12;

  localparam logic [2:0] KIND_ALLOC = 3'd0;
  localparam logic [2:0] KIND_MARK  = 3'd1;
  localparam logic [2:0] KIND_FREE  = 3'd2;
  localparam logic [2:0] KIND_QUERY = 3'd3;
  localparam logic [2:0] KIND_RANGE = 3'd4;

  localparam logic [31:0] USED_BYTES_STEP = 32'h0000_1000;

  typedef struct packed {
    logic [15:0] result_frame;
    logic [27:0] frame_address;
    logic        bit_value;
    logic        status;
    logic [31:0] used_bytes;
  } rsp_t;

  typedef struct packed {
    logic [MAP_WORD_BITS-1:0] new_word;
    logic                     found;
    logic [4:0]               zero_pos;
    logic                     bit_val;
  } wu_out_t;

endpackage

@@ design/bfa_req_if.sv @@
// ----------------------------------------------------------------------------
// bfa_req_if
// Request channel: valid/ready handshake with the allocator request fields.
// ----------------------------------------------------------------------------
interface bfa_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] frame_index;
  logic [16:0] range_length;

  modport source (output valid, output kind, output frame_index, output range_length,
                  input ready);
  modport sink   (input valid, input kind, input frame_index, input range_length,
                  output ready);
endinterface

@@ design/bfa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bfa_rsp_if
// Response channel: valid/ready handshake with the allocator result fields.
// ----------------------------------------------------------------------------
interface bfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_frame;
  logic [27:0] frame_address;
  logic        bit_value;
  logic        status;
  logic [31:0] used_bytes;

  modport source (output valid, output result_frame, output frame_address,
                  output bit_value, output status, output used_bytes, input ready);
  modport sink   (input valid, input result_frame, input frame_address,
                  input bit_value, input status, input used_bytes, output ready);
endinterface

@@ design/bfa_word_unit.sv @@
// ----------------------------------------------------------------------------
// bfa_word_unit
// Shared map word unit: lowest-zero search, single-bit set/clear/test and
// range clear mask over one 32-bit map word.
// ----------------------------------------------------------------------------
module bfa_word_unit
  import bfa_pkg::*;
#(
  parameter int WORD_W = 11,
  parameter int EW     = 18
) (
  input  logic [MAP_WORD_BITS-1:0] word,
  input  logic [2:0]               kind,
  input  logic [4:0]               bit_off,
  input  logic [WORD_W-1:0]        base,
  input  logic [EW-1:0]            lo,
  input  logic [EW-1:0]            hi,
  output wu_out_t                  res
);

  logic [MAP_WORD_BITS-1:0] range_mask;
  logic [MAP_WORD_BITS-1:0] off_bit;
  logic [MAP_WORD_BITS-1:0] zero_bit;
  logic [4:0]               pos;
  logic [EW-1:0]            f;

  always_comb begin
    range_mask = '0;
    f          = '0;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      f = EW'({base, 5'(b)});
      range_mask[b] = (f >= lo) && (f < hi);
    end
  end

  always_comb begin
    pos = '0;
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b]) begin
        pos = 5'(b);
      end
    end
  end

  assign off_bit  = MAP_WORD_BITS'(1) << bit_off;
  assign zero_bit = MAP_WORD_BITS'(1) << pos;

  always_comb begin
    res.found    = (word != '1);
    res.zero_pos = pos;
    res.bit_val  = word[bit_off];
    case (kind)
      KIND_ALLOC: res.new_word = word | zero_bit;
      KIND_MARK:  res.new_word = word | off_bit;
      KIND_FREE:  res.new_word = word & ~off_bit;
      KIND_RANGE: res.new_word = word & ~range_mask;
      default:    res.new_word = word;
    endcase
  end

endmodule

@@ design/bfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer and frame map memory: clear pass, word scan for allocation,
// read-modify-write of single frames and ranges, used byte count.
// ----------------------------------------------------------------------------
module bfa_ctrl
  import bfa_pkg::*;
#(
  parameter int FRAME_COUNT = 65536
) (
  input  logic       clk,
  input  logic       rst,
  bfa_req_if.sink    req,
  output logic       push_valid,
  input  logic       push_ready,
  output rsp_t       push_data
);

  localparam int WORDS  = (FRAME_COUNT + 31) / 32;
  localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int HINT_W = WORD_W + 1;
  localparam int EW     = (WORD_W + 6 > 18) ? WORD_W + 6 : 18;
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(WORDS - 1);
  localparam logic [HINT_W-1:0] NO_HINT   = HINT_W'(WORDS);
  localparam logic [EW-1:0]     FRAME_LIM = EW'(FRAME_COUNT);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_CHECK  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t                   state;
  logic [WORD_W-1:0]        cur;
  logic [WORD_W-1:0]        clr_addr;
  logic [HINT_W-1:0]        hint;
  logic [2:0]               kind_r;
  logic [EW-1:0]            idx_r;
  logic [EW-1:0]            hi_r;
  logic [WORD_W-1:0]        last_word;
  logic [31:0]              used_cnt;
  logic [15:0]              res_frame;
  logic [27:0]              res_addr;
  logic                     res_bit;
  logic                     res_status;

  logic [MAP_WORD_BITS-1:0] mem [WORDS];
  logic [MAP_WORD_BITS-1:0] rdata;
  logic                     wr_en;
  logic [WORD_W-1:0]        wr_addr;
  logic [MAP_WORD_BITS-1:0] wr_data;

  logic [EW-1:0]            idx_ext;
  logic [EW-1:0]            sum;
  logic [EW-1:0]            hi_c;
  logic [EW-1:0]            hi_m1;
  logic                     idx_out;
  logic [EW-1:0]            cur_frame;
  wu_out_t                  wu;

  assign idx_ext   = EW'(req.frame_index);
  assign sum       = idx_ext + EW'(req.range_length);
  assign hi_c      = (sum > FRAME_LIM) ? FRAME_LIM : sum;
  assign hi_m1     = hi_c - EW'(1);
  assign idx_out   = (idx_ext >= FRAME_LIM);
  assign cur_frame = EW'({cur, wu.zero_pos});

  assign req.ready  = (state == S_IDLE);
  assign push_valid = (state == S_RESULT);

  assign push_data.result_frame  = res_frame;
  assign push_data.frame_address = res_addr;
  assign push_data.bit_value     = res_bit;
  assign push_data.status        = res_status;
  assign push_data.used_bytes    = used_cnt;

  bfa_word_unit #(
    .WORD_W (WORD_W),
    .EW     (EW)
  ) u_word_unit (
    .word    (rdata),
    .kind    (kind_r),
    .bit_off (idx_r[4:0]),
    .base    (cur),
    .lo      (idx_r),
    .hi      (hi_r),
    .res     (wu)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = wu.new_word;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '1;
    end else if (state == S_CHECK) begin
      case (kind_r)
        KIND_ALLOC: wr_en = wu.found;
        KIND_MARK:  wr_en = 1'b1;
        KIND_FREE:  wr_en = 1'b1;
        KIND_RANGE: wr_en = 1'b1;
        default:    wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rdata <= mem[cur];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      hint     <= NO_HINT;
      used_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + WORD_W'(1);
          if (clr_addr == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            kind_r     <= req.kind;
            idx_r      <= idx_ext;
            hi_r       <= hi_c;
            last_word  <= hi_m1[WORD_W+4:5];
            cur        <= idx_ext[WORD_W+4:5];
            res_frame  <= req.frame_index;
            res_addr   <= '0;
            res_bit    <= 1'b0;
            res_status <= 1'b0;
            state      <= S_RESULT;
            case (req.kind)
              KIND_ALLOC: begin
                if (hint >= NO_HINT) begin
                  res_frame  <= '0;
                  res_status <= 1'b1;
                end else begin
                  cur   <= hint[WORD_W-1:0];
                  state <= S_READ;
                end
              end
              KIND_MARK, KIND_FREE: begin
                if (!idx_out) begin
                  state <= S_READ;
                end
              end
              KIND_QUERY: begin
                if (idx_out) begin
                  res_bit <= 1'b1;
                end else begin
                  state <= S_READ;
                end
              end
              KIND_RANGE: begin
                if (!idx_out && (req.range_length != '0)) begin
                  state <= S_READ;
                end
              end
              default: state <= S_RESULT;
            endcase
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= S_RESULT;
          case (kind_r)
            KIND_ALLOC: begin
              if (wu.found) begin
                res_frame <= cur_frame[15:0];
                res_addr  <= {cur_frame[15:0], PAGE_SHIFT'(0)};
                used_cnt  <= used_cnt + USED_BYTES_STEP;
                hint      <= HINT_W'(cur);
              end else if (cur == LAST_WORD) begin
                res_frame  <= '0;
                res_status <= 1'b1;
                hint       <= NO_HINT;
              end else begin
                cur   <= cur + WORD_W'(1);
                state <= S_READ;
              end
            end
            KIND_FREE: begin
              if (HINT_W'(cur) < hint) begin
                hint <= HINT_W'(cur);
              end
            end
            KIND_QUERY: begin
              res_bit <= wu.bit_val;
            end
            KIND_RANGE: begin
              if (HINT_W'(cur) < hint) begin
                hint <= HINT_W'(cur);
              end
              if (cur != last_word) begin
                cur   <= cur + WORD_W'(1);
                state <= S_READ;
              end
            end
            default: state <= S_RESULT;
          endcase
        end
        S_RESULT: begin
          if (push_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

@@ design/bfa_out_stage.sv @@
// ----------------------------------------------------------------------------
// bfa_out_stage
// Output register for the response channel; frees the sequencer as soon
// as a result is held.
// ----------------------------------------------------------------------------
module bfa_out_stage
  import bfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  rsp_t       push_data,
  bfa_rsp_if.source  rsp
);

  logic full;
  rsp_t held;

  assign push_ready = !full || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push_valid && push_ready) begin
      full <= 1'b1;
    end else if (rsp.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      held <= push_data;
    end
  end

  assign rsp.valid         = full;
  assign rsp.result_frame  = held.result_frame;
  assign rsp.frame_address = held.frame_address;
  assign rsp.bit_value     = held.bit_value;
  assign rsp.status        = held.status;
  assign rsp.used_bytes    = held.used_bytes;

endmodule

@@ design/bitmap_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit page frame allocator over a one-bit-per-frame map.
//
// Request channel (req): kind, frame_index, range_length. One response per
// request on the response channel (rsp), in request order.
// The map is a memory of 32-bit words, one read or write per cycle, swept
// by a sequencer through one shared word unit.
// Query, mark and free pass through a read and a check state to the result.
// Allocate reads and checks each word it scans; the scan starts at the
// lowest word that may hold a free frame, so it is short in steady use.
// Free range reads and checks each word it touches, 32 frames per word.
// Unknown kinds and out-of-map frames go straight to the result state.
// Reset: all frames read as used, used_bytes is zero. After reset a clear
// pass writes every map word, with req.ready low.
// A held result sits in an output register; the next request is taken while
// it waits, and the sequencer stalls only when a second result is ready.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int FRAME_COUNT = 65536
) (
  input  logic      clk,
  input  logic      rst,
  bfa_req_if.sink   req,
  bfa_rsp_if.source rsp
);

  logic push_valid;
  logic push_ready;
  rsp_t push_data;

  bfa_ctrl #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bfa_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .rsp        (rsp)
  );

endmodule

@@ design/bfa_checker.sv @@
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] result_frame,
  input logic [27:0] frame_address,
  input logic        status,
  input logic [31:0] used_bytes
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> (result_frame == 16'd0) && (frame_address == 28'd0))
    else $error("failed allocate carries a frame");

  a_addr_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (frame_address[11:0] == 12'd0))
    else $error("frame address not page aligned");

  a_count_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (used_bytes[11:0] == 12'd0))
    else $error("used byte count not page aligned");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .result_frame  (rsp.result_frame),
  .frame_address (rsp.frame_address),
  .status        (rsp.status),
  .used_bytes    (rsp.used_bytes)
);

@@ dv/tb_bitmap_frame_allocator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator
// Self-checking bench for the first-fit frame allocator. A scoreboard keeps
// its own copy of the frame map and used byte count, predicts one response
// per accepted request and compares every response field by field, in order.
// The stimulus is a short directed opening (full map, both map ends, empty
// and over-long ranges, spare kinds), then random traffic, mostly near the
// low end of the map, with random gaps on the request side and stalls on
// the response side.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator;
  import bfa_pkg::*;

  localparam int FRAMES      = 65536;
  localparam int MAP_WORDS   = FRAMES / MAP_WORD_BITS;
  localparam int N_ITEMS     = 900;
  localparam int CLK_HALF    = 1;
  localparam int RESET_CYC   = 12;
  localparam int DRAIN_CYC   = 64;
  localparam int MAX_REPORTS = 10;
  localparam int TIMEOUT_NS  = 40_000_000;

  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  class frame_alloc_scoreboard;
    bit [MAP_WORD_BITS-1:0] map_words [MAP_WORDS];
    bit [31:0]              used_bytes;
    int                     free_frames;
    rsp_t                   pending_rsp [$];
    int                     mismatches;

    function new();
      foreach (map_words[w]) map_words[w] = '1;
      used_bytes  = '0;
      free_frames = 0;
      mismatches  = 0;
    endfunction

    function bit frame_used(int f);
      if (f >= FRAMES) return 1'b1;
      return map_words[f / MAP_WORD_BITS][f % MAP_WORD_BITS];
    endfunction

    function void set_frame(int f, bit used);
      if (f >= FRAMES) return;
      if (frame_used(f) != used) free_frames += used ? -1 : 1;
      map_words[f / MAP_WORD_BITS][f % MAP_WORD_BITS] = used;
    endfunction

    function bit lowest_free(output int f);
      f = 0;
      for (int w = 0; w < MAP_WORDS; w++) begin
        if (map_words[w] != '1) begin
          for (int b = 0; b < MAP_WORD_BITS; b++) begin
            if (!map_words[w][b]) begin
              f = w * MAP_WORD_BITS + b;
              return 1'b1;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    // Apply one accepted request and queue the response it must produce.
    function void note_request(logic [2:0] kind, logic [15:0] idx, logic [16:0] len);
      rsp_t r;
      int   f;
      r = '0;
      r.result_frame = idx;
      case (kind)
        KIND_ALLOC: begin
          if (lowest_free(f)) begin
            set_frame(f, 1'b1);
            used_bytes      += USED_BYTES_STEP;
            r.result_frame  = f[15:0];
            r.frame_address = 28'(f << PAGE_SHIFT);
          end else begin
            r.result_frame = '0;
            r.status       = 1'b1;
          end
        end
        KIND_MARK:  set_frame(int'(idx), 1'b1);
        KIND_FREE:  set_frame(int'(idx), 1'b0);
        KIND_QUERY: r.bit_value = frame_used(int'(idx));
        KIND_RANGE: begin
          for (int i = 0; i < int'(len) && int'(idx) + i < FRAMES; i++)
            set_frame(int'(idx) + i, 1'b0);
        end
        default: ;
      endcase
      r.used_bytes = used_bytes;
      pending_rsp.push_back(r);
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want)
        note_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        note_mismatch($sformatf("response with none pending: %p", got));
        return;
      end
      want = pending_rsp.pop_front();
      check_field("result_frame", 32'(want.result_frame), 32'(got.result_frame));
      check_field("frame_address", 32'(want.frame_address), 32'(got.frame_address));
      check_field("bit_value", 32'(want.bit_value), 32'(got.bit_value));
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("used_bytes", want.used_bytes, got.used_bytes);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   req_steady;
  bit   rsp_steady;

  frame_alloc_scoreboard board = new();

  bfa_req_if req ();
  bfa_rsp_if rsp ();

  bitmap_frame_allocator #(
    .FRAME_COUNT(FRAMES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #(CLK_HALF) clk = ~clk;

  task automatic send_request(input logic [2:0] kind, input logic [15:0] idx,
                              input logic [16:0] len);
    int gap;
    if ($urandom_range(0, 39) == 0) req_steady = !req_steady;
    gap = req_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.kind         <= kind;
    req.frame_index  <= idx;
    req.range_length <= len;
    do @(posedge clk); while (req.ready !== 1'b1);
    board.note_request(kind, idx, len);
  endtask

  initial begin : request_source
    int          sent;
    int          roll;
    logic [2:0]  kind;
    logic [15:0] idx;
    logic [16:0] len;

    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.kind         <= KIND_QUERY;
    req.frame_index  <= '0;
    req.range_length <= '0;
    repeat (RESET_CYC) @(posedge clk);
    rst <= 1'b0;

    send_request(KIND_QUERY, 16'h0000, 17'h00000);
    send_request(KIND_ALLOC, 16'hFFFF, 17'h00000);
    send_request(KIND_FREE, 16'h0000, 17'h00000);
    send_request(KIND_FREE, 16'hFFFF, 17'h00000);
    send_request(KIND_QUERY, 16'hFFFF, 17'h00000);
    send_request(KIND_ALLOC, 16'h0000, 17'h00000);
    send_request(KIND_ALLOC, 16'h0000, 17'h00000);
    send_request(KIND_MARK, 16'hFFFF, 17'h00000);
    send_request(KIND_QUERY, 16'hFFFF, 17'h00000);
    send_request(KIND_RANGE, 16'h0000, 17'h00000);
    send_request(KIND_QUERY, 16'h0000, 17'h00000);
    send_request(KIND_RANGE, 16'd100, 17'd40);
    send_request(KIND_QUERY, 16'd139, 17'h00000);
    send_request(KIND_QUERY, 16'd140, 17'h00000);
    send_request(KIND_RANGE, 16'hFFF0, 17'h10000);
    send_request(KIND_SPARE_LO, 16'h5555, 17'h0FFFF);
    send_request(3'(KIND_SPARE_LO + 3'd1), 16'hFFFF, 17'h10000);
    send_request(KIND_SPARE_HI, 16'hAAAA, 17'h00001);
    send_request(KIND_RANGE, 16'h0000, 17'h10000);
    send_request(KIND_MARK, 16'h5555, 17'h00000);
    send_request(KIND_QUERY, 16'h5555, 17'h00000);
    send_request(KIND_QUERY, 16'hAAAA, 17'h00000);
    send_request(KIND_ALLOC, 16'h0000, 17'h00000);
    send_request(KIND_ALLOC, 16'h0000, 17'h00000);

    sent = 0;
    while (sent < N_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) idx = 16'($urandom_range(0, 1023));
      else if (roll < 85) idx = 16'($urandom_range(0, 65535));
      else idx = 16'($urandom_range(65472, 65535));

      roll = $urandom_range(0, 99);
      if (roll < 5) len = '0;
      else if (roll < 70) len = 17'($urandom_range(1, 64));
      else if (roll < 95) len = 17'($urandom_range(65, 2048));
      else len = 17'($urandom_range(0, 65536));

      roll = $urandom_range(0, 99);
      if (roll < 30) kind = KIND_ALLOC;
      else if (roll < 44) kind = KIND_MARK;
      else if (roll < 60) kind = KIND_FREE;
      else if (roll < 80) kind = KIND_QUERY;
      else if (roll < 96) kind = KIND_RANGE;
      else kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));

      // hold off most allocations on a full map, each one may scan up to the last word
      if (kind == KIND_ALLOC && board.free_frames == 0 && $urandom_range(0, 7) != 0)
        kind = KIND_FREE;
      if (kind != KIND_RANGE && $urandom_range(0, 3) != 0) len = '0;

      send_request(kind, idx, len);
      if (kind <= KIND_RANGE) sent++;
    end
    req.valid <= 1'b0;

    while (board.pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("tb_bitmap_frame_allocator: done, clean");
    end else begin
      $display("tb_bitmap_frame_allocator: done, errors");
    end
    $finish;
  end

  initial begin : response_sink
    int stall;
    rsp.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) rsp_steady = !rsp_steady;
      stall = rsp_steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      // ready is high at each edge below, so valid alone marks the transfer
      do @(posedge clk); while (rsp.valid !== 1'b1);
      board.check_response({rsp.result_frame, rsp.frame_address, rsp.bit_value,
                            rsp.status, rsp.used_bytes});
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_bitmap_frame_allocator: done, errors");
    $finish;
  end

endmodule
